// File: hw/rtl/cu_pkg.sv
package cu_pkg;

    localparam int MAX_POS = 32;
    localparam int TBL     = MAX_POS + 1;
    localparam int IDX_W   = $clog2(TBL);
    localparam int CNT_W   = 6;
    localparam int RANK_W  = 30;
    localparam int BIN_W   = RANK_W;
    localparam int MASK_W  = 32;
    localparam int P_W     = $clog2(MASK_W);

    // Table index of x - d, or zero when that falls outside the table.
    function automatic logic [IDX_W-1:0] idx_sub(input logic [CNT_W-1:0] x,
                                                  input logic [1:0]       d);
        logic [CNT_W:0] t;
        logic [IDX_W-1:0] res;
        t = {1'b0, x} - (CNT_W + 1)'(d);
        if (t[CNT_W] || (t > (CNT_W + 1)'(MAX_POS))) begin
            res = '0;
        end else begin
            res = t[IDX_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/combination_unrank.sv
// combination_unrank: lexicographic combination unranking.
// A request is taken at a rising edge where start is high and busy is low:
// position_count n, chosen_count k and the 1-based rank. The block returns
// on position_mask the k-subset of 0..n-1 with that rank, one bit per
// chosen position. done is high for exactly one cycle with the result;
// the receiver cannot stall, so the result must be taken in that cycle.
// rank_error is set, with a zero mask, for n > 32, k > n, rank = 0 or
// rank > C(n,k).
// Binomial counts sit in a 33 x 33 synchronous table with two read ports.
// Both candidate counts for the next position are read ahead, so one
// position is decided per cycle. A request that passes the input checks
// runs from acceptance through the check state, which also decides
// position 0, then the run state for each further position up to the
// last chosen one, then done; a rank above C(n,k) or k = 0 ends after
// the check state. A request with bad counts or a zero rank gives
// done in the next cycle. busy falls with done, so the next request may
// be taken in the done cycle.
// After reset the table is built by Pascal's rule, one entry a cycle:
// busy stays high while the table is built, and no request is taken before.
module combination_unrank (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cu_pkg::CNT_W-1:0]      position_count,
    input  logic [cu_pkg::CNT_W-1:0]      chosen_count,
    input  logic [cu_pkg::RANK_W-1:0]     rank,
    output logic                          done,
    output logic [cu_pkg::MASK_W-1:0]     position_mask,
    output logic                          rank_error
);

    typedef enum logic [2:0] {
        ST_FILL,
        ST_DRAIN,
        ST_IDLE,
        ST_CHECK,
        ST_RUN
    } state_t;

    localparam logic [cu_pkg::IDX_W-1:0] LAST_IDX = cu_pkg::IDX_W'(cu_pkg::MAX_POS);

    logic [cu_pkg::BIN_W-1:0] mem [0:cu_pkg::TBL-1][0:cu_pkg::TBL-1];

    state_t                     state_reg, state_next;
    logic [cu_pkg::IDX_W-1:0]   fill_m_reg, fill_m_next;
    logic [cu_pkg::IDX_W-1:0]   fill_c_reg, fill_c_next;
    logic                       wr_valid_reg, wr_valid_next;
    logic [cu_pkg::IDX_W-1:0]   wr_m_reg, wr_m_next;
    logic [cu_pkg::IDX_W-1:0]   wr_c_reg, wr_c_next;
    logic [cu_pkg::BIN_W-1:0]   prev_reg;
    logic [cu_pkg::BIN_W-1:0]   wr_data;

    logic [cu_pkg::IDX_W-1:0]   ra_m, ra_c, rb_m, rb_c;
    logic [cu_pkg::BIN_W-1:0]   rd_a_reg, rd_b_reg;

    logic [cu_pkg::CNT_W-1:0]   m_reg, m_next;
    logic [cu_pkg::CNT_W-1:0]   left_reg, left_next;
    logic [cu_pkg::RANK_W-1:0]  r_reg, r_next;
    logic [cu_pkg::P_W-1:0]     p_reg, p_next;
    logic                       took_reg, took_next;
    logic [cu_pkg::MASK_W-1:0]  mask_reg, mask_next;

    logic                       done_reg, done_next;
    logic [cu_pkg::MASK_W-1:0]  mask_out_reg, mask_out_next;
    logic                       err_reg, err_next;

    logic                       bad_in;
    logic [cu_pkg::BIN_W-1:0]   cnt;
    logic                       take;
    logic [cu_pkg::CNT_W-1:0]   m_step, left_step;
    logic [cu_pkg::RANK_W-1:0]  r_step;
    logic [cu_pkg::MASK_W-1:0]  mask_step;

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign position_mask = mask_out_reg;
    assign rank_error    = err_reg;

    assign bad_in = (position_count > cu_pkg::CNT_W'(cu_pkg::MAX_POS))
                 || (chosen_count > position_count)
                 || (rank == '0);

    assign wr_data = (wr_m_reg == '0) ? cu_pkg::BIN_W'(wr_c_reg == '0)
                   : cu_pkg::BIN_W'(rd_a_reg + ((wr_c_reg == '0) ? '0 : prev_reg));

    assign cnt       = took_reg ? rd_a_reg : rd_b_reg;
    assign take      = (r_reg <= cnt);
    assign m_step    = m_reg - cu_pkg::CNT_W'(1);
    assign left_step = take ? left_reg - cu_pkg::CNT_W'(1) : left_reg;
    assign r_step    = take ? r_reg : r_reg - cnt;

    always_comb
    begin
        mask_step = mask_reg;
        if (take)
        begin
            mask_step[p_reg] = 1'b1;
        end
    end

    always_comb
    begin
        unique case (state_reg) inside
            ST_FILL, ST_DRAIN:
            begin
                ra_m = cu_pkg::idx_sub(cu_pkg::CNT_W'(fill_m_reg), 2'd1);
                ra_c = fill_c_reg;
                rb_m = ra_m;
                rb_c = ra_c;
            end
            ST_IDLE:
            begin
                ra_m = cu_pkg::idx_sub(position_count, 2'd0);
                ra_c = cu_pkg::idx_sub(chosen_count, 2'd0);
                rb_m = cu_pkg::idx_sub(position_count, 2'd1);
                rb_c = cu_pkg::idx_sub(chosen_count, 2'd1);
            end
            default:
            begin
                ra_m = cu_pkg::idx_sub(m_reg, 2'd2);
                ra_c = cu_pkg::idx_sub(left_reg, 2'd2);
                rb_m = ra_m;
                rb_c = cu_pkg::idx_sub(left_reg, 2'd1);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid_reg)
        begin
            mem[wr_m_reg][wr_c_reg] <= wr_data;
        end
        rd_a_reg <= mem[ra_m][ra_c];
        rd_b_reg <= mem[rb_m][rb_c];
        prev_reg <= rd_a_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_m_next   = fill_m_reg;
        fill_c_next   = fill_c_reg;
        wr_valid_next = 1'b0;
        wr_m_next     = wr_m_reg;
        wr_c_next     = wr_c_reg;
        m_next        = m_reg;
        left_next     = left_reg;
        r_next        = r_reg;
        p_next        = p_reg;
        took_next     = took_reg;
        mask_next     = mask_reg;
        done_next     = 1'b0;
        mask_out_next = mask_out_reg;
        err_next      = err_reg;

        unique case (state_reg) inside
            ST_FILL:
            begin
                wr_valid_next = 1'b1;
                wr_m_next     = fill_m_reg;
                wr_c_next     = fill_c_reg;
                if (fill_c_reg == LAST_IDX)
                begin
                    fill_c_next = '0;
                    fill_m_next = fill_m_reg + cu_pkg::IDX_W'(1);
                    if (fill_m_reg == LAST_IDX)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    fill_c_next = fill_c_reg + cu_pkg::IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (bad_in)
                    begin
                        done_next     = 1'b1;
                        mask_out_next = '0;
                        err_next      = 1'b1;
                    end
                    else
                    begin
                        m_next     = position_count;
                        left_next  = chosen_count;
                        r_next     = rank;
                        p_next     = '0;
                        took_next  = 1'b0;
                        mask_next  = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK, ST_RUN:
            begin
                if ((state_reg == ST_CHECK) && (r_reg > rd_a_reg))
                begin
                    done_next     = 1'b1;
                    mask_out_next = '0;
                    err_next      = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if ((left_reg == '0) || (m_reg == '0))
                begin
                    done_next     = 1'b1;
                    mask_out_next = mask_reg;
                    err_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    m_next    = m_step;
                    left_next = left_step;
                    r_next    = r_step;
                    p_next    = p_reg + cu_pkg::P_W'(1);
                    took_next = take;
                    mask_next = mask_step;
                    if ((left_step == '0) || (m_step == '0))
                    begin
                        done_next     = 1'b1;
                        mask_out_next = mask_step;
                        err_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            fill_m_reg   <= '0;
            fill_c_reg   <= '0;
            wr_valid_reg <= 1'b0;
            wr_m_reg     <= '0;
            wr_c_reg     <= '0;
            m_reg        <= '0;
            left_reg     <= '0;
            r_reg        <= '0;
            p_reg        <= '0;
            took_reg     <= 1'b0;
            mask_reg     <= '0;
            done_reg     <= 1'b0;
            mask_out_reg <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_m_reg   <= fill_m_next;
            fill_c_reg   <= fill_c_next;
            wr_valid_reg <= wr_valid_next;
            wr_m_reg     <= wr_m_next;
            wr_c_reg     <= wr_c_next;
            m_reg        <= m_next;
            left_reg     <= left_next;
            r_reg        <= r_next;
            p_reg        <= p_next;
            took_reg     <= took_next;
            mask_reg     <= mask_next;
            done_reg     <= done_next;
            mask_out_reg <= mask_out_next;
            err_reg      <= err_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rank_error && (position_mask != '0)))
        else $error("error result carries a non-zero mask");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request produced neither work nor result");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FILL) || (state_reg == ST_DRAIN)) |-> !done)
        else $error("result strobed while the table is being built");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FILL) && wr_valid_reg)
            |-> !((ra_m == wr_m_reg) && (ra_c == wr_c_reg)))
        else $error("table read and write hit the same entry during the build");

endmodule

// File: tb/sv/combination_unrank_tb.sv
module combination_unrank_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [cu_pkg::CNT_W-1:0]  n;
        logic [cu_pkg::CNT_W-1:0]  k;
        logic [cu_pkg::RANK_W-1:0] r;
    } unrank_req_t;

    typedef struct packed {
        logic [cu_pkg::MASK_W-1:0] mask;
        logic                      err;
    } unrank_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [cu_pkg::CNT_W-1:0]   position_count = '0;
    logic [cu_pkg::CNT_W-1:0]   chosen_count = '0;
    logic [cu_pkg::RANK_W-1:0]  rank = '0;
    logic                       done;
    logic [cu_pkg::MASK_W-1:0]  position_mask;
    logic                       rank_error;

    longint unsigned    binom [0:cu_pkg::MAX_POS][0:cu_pkg::MAX_POS];
    unrank_req_t        pending_requests[$];
    unrank_t            expected_unranks[$];
    int                 requests_sent = 0;
    int                 requests_taken = 0;
    int                 mismatches = 0;
    int                 idle_left = 0;
    bit                 back_to_back = 1'b0;

    combination_unrank dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .position_count (position_count),
        .chosen_count   (chosen_count),
        .rank           (rank),
        .done           (done),
        .position_mask  (position_mask),
        .rank_error     (rank_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic unrank_t unrank_lex(input logic [cu_pkg::CNT_W-1:0] n,
                                           input logic [cu_pkg::CNT_W-1:0] k,
                                           input logic [cu_pkg::RANK_W-1:0] r);
        unrank_t         res;
        longint unsigned rest;
        longint unsigned c;
        int              left;
        int              p;
        res.mask = '0;
        res.err  = 1'b0;
        rest     = r;
        if (n > cu_pkg::MAX_POS || k > n || r == 0)
        begin
            res.err = 1'b1;
        end
        else if (rest > binom[n][k])
        begin
            res.err = 1'b1;
        end
        else
        begin
            left = k;
            for (p = 0; p < n && left > 0; p++)
            begin
                c = binom[n - p - 1][left - 1];
                if (rest <= c)
                begin
                    res.mask[p] = 1'b1;
                    left--;
                end
                else
                begin
                    rest -= c;
                end
            end
        end
        return res;
    endfunction

    task automatic add_request(input logic [cu_pkg::CNT_W-1:0] n,
                               input logic [cu_pkg::CNT_W-1:0] k,
                               input logic [cu_pkg::RANK_W-1:0] r);
        unrank_req_t req;
        req.n = n;
        req.k = k;
        req.r = r;
        pending_requests.push_back(req);
    endtask

    // driver: hold a request until taken, then idle or advance
    always @(negedge clk)
    begin : driver
        unrank_req_t req;
        int          sel;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && requests_taken < requests_sent)
        begin
            start <= 1'b1;
        end
        else if (idle_left > 0)
        begin
            start <= 1'b0;
            idle_left <= idle_left - 1;
        end
        else if (pending_requests.size() != 0)
        begin
            req = pending_requests.pop_front();
            position_count <= req.n;
            chosen_count   <= req.k;
            rank           <= req.r;
            start          <= 1'b1;
            requests_sent  <= requests_sent + 1;
            if ($urandom_range(0, 63) == 0)
                back_to_back <= !back_to_back;
            sel = $urandom_range(0, 99);
            if (back_to_back || sel < 50)
                idle_left <= 0;
            else if (sel < 85)
                idle_left <= $urandom_range(1, 3);
            else if (sel < 97)
                idle_left <= $urandom_range(4, 12);
            else
                idle_left <= $urandom_range(20, 80);
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // monitor: check results, then record the request taken at this edge
    always @(posedge clk)
    begin : monitor
        unrank_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_unranks.size() == 0)
                begin
                    $error("unexpected result: position_mask %h rank_error %b",
                           position_mask, rank_error);
                    mismatches++;
                end
                else
                begin
                    want = expected_unranks.pop_front();
                    if (position_mask !== want.mask)
                    begin
                        $error("position_mask: expected %h, actual %h",
                               want.mask, position_mask);
                        mismatches++;
                    end
                    if (rank_error !== want.err)
                    begin
                        $error("rank_error: expected %b, actual %b", want.err, rank_error);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_unranks.push_back(unrank_lex(position_count, chosen_count, rank));
                requests_taken++;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int              m;
        int              c;
        int              i;
        int              sel;
        int              n_i;
        int              k_i;
        longint unsigned total;
        longint unsigned r;

        for (m = 0; m <= cu_pkg::MAX_POS; m++)
        begin
            for (c = 0; c <= cu_pkg::MAX_POS; c++)
            begin
                if (c == 0)
                    binom[m][c] = 1;
                else if (m == 0)
                    binom[m][c] = 0;
                else
                    binom[m][c] = binom[m - 1][c - 1] + binom[m - 1][c];
            end
        end

        add_request(6'd0, 6'd0, 30'd1);
        add_request(6'd0, 6'd0, 30'd0);
        add_request(6'd0, 6'd0, 30'd2);
        add_request(6'd1, 6'd1, 30'd1);
        add_request(6'd1, 6'd0, 30'd1);
        add_request(6'd32, 6'd0, 30'd1);
        add_request(6'd32, 6'd0, 30'd2);
        add_request(6'd32, 6'd32, 30'd1);
        add_request(6'd32, 6'd32, 30'd2);
        add_request(6'd32, 6'd16, 30'd1);
        add_request(6'd32, 6'd16, 30'd601080390);
        add_request(6'd32, 6'd16, 30'd601080391);
        add_request(6'd32, 6'd16, 30'h3FFFFFFF);
        add_request(6'd32, 6'd1, 30'd1);
        add_request(6'd32, 6'd1, 30'd32);
        add_request(6'd32, 6'd31, 30'd17);
        add_request(6'd33, 6'd0, 30'd1);
        add_request(6'd63, 6'd63, 30'd1);
        add_request(6'd63, 6'd0, 30'd1);
        add_request(6'd5, 6'd6, 30'd1);
        add_request(6'd0, 6'd63, 30'd1);
        add_request(6'd20, 6'd10, 30'h3FFFFFFF);
        add_request(6'd7, 6'd3, 30'd20);
        add_request(6'd31, 6'd15, 30'd300540195);

        for (i = 0; i < 1930; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 12)
            begin
                add_request(6'($urandom), 6'($urandom), 30'($urandom));
            end
            else
            begin
                n_i   = $urandom_range(0, cu_pkg::MAX_POS);
                k_i   = $urandom_range(0, n_i);
                total = binom[n_i][k_i];
                if (sel < 20)
                    r = total;
                else if (sel < 26)
                    r = 1;
                else if (sel < 30)
                    r = total + 1;
                else
                    r = $urandom_range(32'(total), 1);
                add_request(6'(n_i), 6'(k_i), 30'(r));
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || start || expected_unranks.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: combination_unrank.f
hw/rtl/cu_pkg.sv
hw/rtl/combination_unrank.sv
tb/sv/combination_unrank_tb.sv
